@@ rtl/symbol_range_lookup_unit_macros.svh @@
// Assertion macros shared by the symbol range lookup RTL.
`ifndef SYMBOL_RANGE_LOOKUP_UNIT_MACROS_SVH
`define SYMBOL_RANGE_LOOKUP_UNIT_MACROS_SVH

`ifndef SYNTH
`define SRL_ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("symbol range lookup: same-cycle check failed");
`define SRL_ASSERT_NXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("symbol range lookup: next-cycle check failed");
`else
`define SRL_ASSERT_IMP(label, ante, cons)
`define SRL_ASSERT_NXT(label, ante, cons)
`endif

`endif

@@ rtl/srl_pkg.sv @@
// Types and fixed field widths of the symbol range lookup unit.
package srl_pkg;

  localparam int IDX_W  = 10;
  localparam int ADDR_W = 64;
  localparam int CNT_W  = 11;
  localparam int IN_DATA_W  = 80;
  localparam int OUT_DATA_W = 80;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SEARCH,
    ST_FIN
  } srl_state_t;

  typedef enum logic {
    MODE_LOAD   = 1'b0,
    MODE_LOOKUP = 1'b1
  } srl_mode_t;

endpackage

@@ rtl/srl_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
module srl_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem_r[raddr];
    end
  end

endmodule

@@ rtl/symbol_range_lookup_unit.sv @@
// Top level of the symbol range lookup unit: sorted start table and floor search.
`include "symbol_range_lookup_unit_macros.svh"

// A load transfer writes one start address into the table.
// A lookup transfer is taken in ST_IDLE, which issues the first read unless
// the count is zero; then ST_SEARCH makes one probe per step of the binary
// search, at most floor(log2(count)) + 1 probes, and ST_FIN places the result
// in the output register. Each probe is one read of the start-address memory, whose
// registered data is compared and used to form the next probe address in the
// same cycle. A new transfer is taken while an earlier result still waits.
module symbol_range_lookup_unit
  import srl_pkg::*;
#(
  parameter int TABLE_DEPTH = 1024
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  input  logic [IN_DATA_W-1:0]  in_tdata,   // entry_index[9:0], address[73:10]
  input  logic                  in_tuser,   // mode[0]
  output logic                  out_tvalid,
  input  logic                  out_tready,
  output logic [OUT_DATA_W-1:0] out_tdata,  // symbol_index[9:0], offset[73:10]
  output logic                  out_tuser,  // found[0]
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CNT_W-1:0]      cfg_data    // symbol_count[10:0]
);

  localparam int AW = $clog2(TABLE_DEPTH);
  localparam int LW = $clog2(TABLE_DEPTH + 1);

  srl_state_t state_r, state_nxt;

  logic [CNT_W-1:0]  count_r;
  logic [LW-1:0]     lo_r, lo_nxt, hi_r, hi_nxt, mid_r, mid_nxt;
  logic [ADDR_W-1:0] addr_r, addr_nxt, hit_start_r, hit_start_nxt;
  logic              found_r, found_nxt;
  logic              out_valid_r, out_valid_nxt;
  logic              res_found_r, res_found_nxt;
  logic [IDX_W-1:0]  res_idx_r, res_idx_nxt;
  logic [ADDR_W-1:0] res_offset_r, res_offset_nxt;

  logic [IDX_W-1:0]  in_entry_index;
  logic [ADDR_W-1:0] in_address;
  logic              in_accept;
  logic [LW-1:0]     eff_count;
  logic              ram_we, ram_re;
  logic [AW-1:0]     ram_raddr;
  logic [ADDR_W-1:0] ram_rdata;
  logic              probe_le;
  logic [LW-1:0]     probe_lo, probe_hi, probe_mid;
  logic              out_load;
  logic [LW-1:0]     hit_idx;

  assign in_entry_index = in_tdata[IDX_W-1:0];
  assign in_address     = in_tdata[IDX_W +: ADDR_W];
  assign in_tready      = (state_r == ST_IDLE);
  assign in_accept      = in_tvalid && in_tready;
  assign cfg_ready      = 1'b1;

  assign eff_count = (32'(count_r) > TABLE_DEPTH) ? LW'(TABLE_DEPTH) : LW'(count_r);

  assign ram_we = in_accept && (in_tuser == MODE_LOAD) &&
                  (32'(in_entry_index) < TABLE_DEPTH);

  srl_ram #(
    .WIDTH(ADDR_W),
    .DEPTH(TABLE_DEPTH)
  ) u_starts (
    .clk  (clk),
    .we   (ram_we),
    .waddr(AW'(in_entry_index)),
    .wdata(in_address),
    .re   (ram_re),
    .raddr(ram_raddr),
    .rdata(ram_rdata)
  );

  // One probe: compare the returned start, narrow the range, form the next mid.
  assign probe_le  = (ram_rdata <= addr_r);
  assign probe_lo  = probe_le ? (mid_r + LW'(1)) : lo_r;
  assign probe_hi  = probe_le ? hi_r : mid_r;
  assign probe_mid = probe_lo + ((probe_hi - probe_lo) >> 1);

  assign out_load = (state_r == ST_FIN) && (!out_valid_r || out_tready);
  assign hit_idx  = lo_r - LW'(1);

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_accept && (in_tuser == MODE_LOOKUP)) begin
          state_nxt = (eff_count == '0) ? ST_FIN : ST_SEARCH;
        end
      end
      ST_SEARCH: begin
        if (!(probe_lo < probe_hi)) begin
          state_nxt = ST_FIN;
        end
      end
      ST_FIN: begin
        if (out_load) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    lo_nxt         = lo_r;
    hi_nxt         = hi_r;
    mid_nxt        = mid_r;
    addr_nxt       = addr_r;
    hit_start_nxt  = hit_start_r;
    found_nxt      = found_r;
    ram_re         = 1'b0;
    ram_raddr      = AW'(mid_r);
    res_found_nxt  = res_found_r;
    res_idx_nxt    = res_idx_r;
    res_offset_nxt = res_offset_r;
    out_valid_nxt  = out_tready ? 1'b0 : out_valid_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_accept && (in_tuser == MODE_LOOKUP)) begin
          lo_nxt    = '0;
          hi_nxt    = eff_count;
          mid_nxt   = eff_count >> 1;
          addr_nxt  = in_address;
          found_nxt = 1'b0;
          ram_re    = (eff_count != '0);
          ram_raddr = AW'(eff_count >> 1);
        end
      end
      ST_SEARCH: begin
        lo_nxt  = probe_lo;
        hi_nxt  = probe_hi;
        mid_nxt = probe_mid;
        if (probe_le) begin
          found_nxt     = 1'b1;
          hit_start_nxt = ram_rdata;
        end
        if (probe_lo < probe_hi) begin
          ram_re    = 1'b1;
          ram_raddr = AW'(probe_mid);
        end
      end
      ST_FIN: begin
        if (out_load) begin
          out_valid_nxt  = 1'b1;
          res_found_nxt  = found_r;
          res_idx_nxt    = found_r ? IDX_W'(hit_idx) : '0;
          res_offset_nxt = found_r ? (addr_r - hit_start_r) : '0;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
      count_r     <= '0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_valid && cfg_ready) begin
        count_r <= cfg_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    lo_r         <= lo_nxt;
    hi_r         <= hi_nxt;
    mid_r        <= mid_nxt;
    addr_r       <= addr_nxt;
    hit_start_r  <= hit_start_nxt;
    found_r      <= found_nxt;
    res_found_r  <= res_found_nxt;
    res_idx_r    <= res_idx_nxt;
    res_offset_r <= res_offset_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tuser  = res_found_r;
  assign out_tdata  = {{(OUT_DATA_W - IDX_W - ADDR_W){1'b0}}, res_offset_r, res_idx_r};

  `SRL_ASSERT_IMP(a_busy_not_ready, state_r != ST_IDLE, !in_tready)
  `SRL_ASSERT_IMP(a_probe_in_range, state_r == ST_SEARCH, (mid_r >= lo_r) && (mid_r < hi_r))
  `SRL_ASSERT_IMP(a_miss_zero, out_tvalid && !out_tuser, out_tdata == '0)
  `SRL_ASSERT_NXT(a_fin_holds, (state_r == ST_FIN) && out_valid_r && !out_tready, state_r == ST_FIN)

endmodule
